// File: rtl/qvr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the quaternion vector rotator.
package qvr_pkg;

	localparam int VEC_W  = 32;
	localparam int QUAT_W = 32;
	localparam int ROT_W  = 32;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_QUAT_W = 2'd0;
	localparam logic [1:0] REG_QUAT_X = 2'd1;
	localparam logic [1:0] REG_QUAT_Y = 2'd2;
	localparam logic [1:0] REG_QUAT_Z = 2'd3;

	localparam logic [31:0] QUAT_W_RESET = 32'h4000_0000;

	typedef logic signed [67:0] wide_t;

	// Starting guess of 1/sqrt(u), Q2.12, indexed by the top four bits of u
	function automatic logic [12:0] rsqrt_seed(input logic [3:0] idx);
		logic [12:0] r;
		case (idx)
			4'd4:    r = 13'd3862;
			4'd5:    r = 13'd3493;
			4'd6:    r = 13'd3213;
			4'd7:    r = 13'd2991;
			4'd8:    r = 13'd2810;
			4'd9:    r = 13'd2658;
			4'd10:   r = 13'd2528;
			4'd11:   r = 13'd2416;
			4'd12:   r = 13'd2317;
			4'd13:   r = 13'd2230;
			4'd14:   r = 13'd2151;
			4'd15:   r = 13'd2081;
			default: r = 13'd4096;
		endcase
		return r;
	endfunction

	// Arithmetic right shift, rounded half away from zero
	function automatic wide_t shr_round(input wide_t v, input int s);
		wide_t half;
		wide_t negc;
		half = wide_t'(1) <<< (s - 1);
		negc = v[67] ? wide_t'(1) : wide_t'(0);
		return (v + half - negc) >>> s;
	endfunction

	function automatic logic [31:0] sat32(input wide_t v);
		logic [31:0] r;
		if (v > wide_t'(64'sh7FFF_FFFF))
			r = 32'h7FFF_FFFF;
		else if (v < -wide_t'(64'sh8000_0000))
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// File: rtl/qvr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input vectors and rotated results.
interface qvr_vec_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;

	modport source (output valid, vec_x, vec_y, vec_z, input ready);
	modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface qvr_rot_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] rot_x;
	logic signed [31:0] rot_y;
	logic signed [31:0] rot_z;
	logic               zero_vector;

	modport source (output valid, rot_x, rot_y, rot_z, zero_vector, input ready);
	modport sink   (input valid, rot_x, rot_y, rot_z, zero_vector, output ready);
endinterface

// File: rtl/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// Quaternion vector rotator: normalize a Q15.16 vector, rotate it by q*v*conj(q).
//
// Takes one vector item per clock while the output register is not held, and
// returns one result item per item, in order. Stages s1 to s5 split the signs,
// square, sum, find the even normalizing shift and look up the seed; each Newton
// step (three by default) has stages a, b and c (y*y, then times u, then the
// correction multiply); s6 and s7 scale the components; s8 and s9 form the first
// Hamilton product, and s10 and the output register form the second. The whole
// pipe advances as one whenever the output register is empty or being taken, so a
// held result stalls every stage and nothing is lost.
// The quaternion registers feed the Hamilton products directly; write them only
// while no item is in flight. The quaternion is not normalized, and a zero vector
// yields a zero result with zero_vector set.
module quaternion_vector_rotate #(
	parameter int RSQRT_ITERATIONS = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	qvr_vec_if.sink          vec,
	qvr_rot_if.source        rot,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [31:0]      cfg_data
);

	localparam int NI = RSQRT_ITERATIONS;

	typedef struct packed {
		logic [2:0]       neg;
		logic [2:0][31:0] mag;
		logic             zero;
		logic [5:0]       k;
	} side_t;

	// Quaternion registers
	logic signed [31:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	logic signed [31:0] qs [4];

	// Global advance: the pipe moves when the output register can take an item
	logic adv;

	// Front end
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	side_t              side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [63:0]        sq_s2 [3];
	logic [63:0]        sum_s3, sum_s4;
	logic [5:0]         k_c;
	logic [63:0]        m_c;
	logic [31:0]        u_s5, y_s5;

	// Newton chain: three stages per step
	logic               vld_sn [NI+1];
	side_t              side_sn [NI+1];
	logic [31:0]        u_sn [NI+1];
	logic [31:0]        y_sn [NI+1];

	// Back end
	logic               vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic               zero_s6, zero_s7, zero_s8, zero_s9, zero_s10;
	side_t              side_s6;
	logic [63:0]        sc_s6 [3];
	logic signed [31:0] n_s7 [3];
	logic signed [63:0] pnq_s8 [3][4];
	logic signed [33:0] t_s9 [4];
	logic signed [65:0] pqt_s10 [4][4];
	logic signed [31:0] n_c [3];
	logic signed [33:0] t_c [4];
	logic [31:0]        r_c [3];

	assign qs[0] = quat_w_q;
	assign qs[1] = quat_x_q;
	assign qs[2] = quat_y_q;
	assign qs[3] = quat_z_q;

	// Configuration writes; unknown indexes cannot occur with a two-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_w_q <= qvr_pkg::QUAT_W_RESET;
			quat_x_q <= '0;
			quat_y_q <= '0;
			quat_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				qvr_pkg::REG_QUAT_W: quat_w_q <= cfg_data;
				qvr_pkg::REG_QUAT_X: quat_x_q <= cfg_data;
				qvr_pkg::REG_QUAT_Y: quat_y_q <= cfg_data;
				qvr_pkg::REG_QUAT_Z: quat_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv       = !rot.valid || rot.ready;
	assign vec.ready = adv;

	// Valid bits of the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			rot.valid <= 1'b0;
		end else if (adv) begin
			vld_s1  <= vec.valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_sn[NI];
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			rot.valid <= vld_s10;
		end
	end

	// s1: split each component into sign and magnitude, flag the zero vector
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.neg  <= {vec.vec_z[31], vec.vec_y[31], vec.vec_x[31]};
			side_s1.mag[0] <= vec.vec_x[31] ? 32'(-vec.vec_x) : vec.vec_x;
			side_s1.mag[1] <= vec.vec_y[31] ? 32'(-vec.vec_y) : vec.vec_y;
			side_s1.mag[2] <= vec.vec_z[31] ? 32'(-vec.vec_z) : vec.vec_z;
			side_s1.zero <= (vec.vec_x == '0) && (vec.vec_y == '0) && (vec.vec_z == '0);
			side_s1.k    <= '0;
		end
	end

	// s2: square each magnitude
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				sq_s2[i] <= 64'(side_s1.mag[i]) * 64'(side_s1.mag[i]);
			side_s2 <= side_s1;
		end
	end

	// s3: sum of squares, exact in 64 bits
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			side_s3 <= side_s2;
		end
	end

	// Even left shift that brings the top bit pair to nonzero
	always_comb begin
		k_c = '0;
		for (int j = 0; j < 32; j++)
			if (|sum_s3[2*j +: 2])
				k_c = 6'(62 - 2*j);
	end

	// s4: hold the shift count
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4  <= sum_s3;
			side_s4 <= '{neg: side_s3.neg, mag: side_s3.mag, zero: side_s3.zero, k: k_c};
		end
	end

	assign m_c = sum_s4 << side_s4.k;

	// s5: mantissa u in Q2.30 and the table guess
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s5    <= m_c[63:32];
			y_s5    <= {1'b0, qvr_pkg::rsqrt_seed(m_c[63:60]), 18'd0};
			side_s5 <= side_s4;
		end
	end

	assign vld_sn[0]  = vld_s5;
	assign side_sn[0] = side_s5;
	assign u_sn[0]    = u_s5;
	assign y_sn[0]    = y_s5;

	// Newton steps for 1/sqrt(u)
	for (genvar g = 0; g < NI; g++) begin : g_newton
		logic        vld_a_sn, vld_b_sn, vld_c_sn;
		side_t       side_a_sn, side_b_sn, side_c_sn;
		logic [31:0] u_a_sn, u_b_sn, u_c_sn;
		logic [31:0] y_a_sn, y_b_sn, y_c_sn;
		logic [63:0] yy_a_sn;
		logic [33:0] p_b_sn;
		logic [65:0] tu;
		logic [31:0] diff;
		logic [63:0] ycorr;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a_sn <= 1'b0;
				vld_b_sn <= 1'b0;
				vld_c_sn <= 1'b0;
			end else if (adv) begin
				vld_a_sn <= vld_sn[g];
				vld_b_sn <= vld_a_sn;
				vld_c_sn <= vld_b_sn;
			end
		end

		assign tu    = 66'(yy_a_sn[63:30]) * 66'(u_a_sn);
		assign diff  = 32'(34'(3) << 30) - p_b_sn[31:0];
		assign ycorr = 64'(y_b_sn) * 64'(diff);

		always_ff @(posedge clk) begin
			if (adv) begin
				yy_a_sn   <= 64'(y_sn[g]) * 64'(y_sn[g]);
				y_a_sn    <= y_sn[g];
				u_a_sn    <= u_sn[g];
				side_a_sn <= side_sn[g];

				p_b_sn    <= tu[63:30];
				y_b_sn    <= y_a_sn;
				u_b_sn    <= u_a_sn;
				side_b_sn <= side_a_sn;

				// underflow of the correction term drives y to zero
				y_c_sn    <= (p_b_sn >= (34'(3) << 30)) ? '0 : ycorr[62:31];
				u_c_sn    <= u_b_sn;
				side_c_sn <= side_b_sn;
			end
		end

		assign vld_sn[g+1]  = vld_c_sn;
		assign side_sn[g+1] = side_c_sn;
		assign u_sn[g+1]    = u_c_sn;
		assign y_sn[g+1]    = y_c_sn;
	end

	// s6: scale each magnitude by 1/sqrt(S)
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				sc_s6[i] <= 64'(side_sn[NI].mag[i]) * 64'(y_sn[NI]);
			side_s6 <= side_sn[NI];
			zero_s6 <= side_sn[NI].zero;
		end
	end

	// Round by 31 - k/2, clamp to one, restore the sign
	always_comb begin
		logic [4:0]  sh;
		logic [64:0] half;
		logic [64:0] rnd;
		sh   = 5'd31 - side_s6.k[5:1];
		half = (sh == '0) ? '0 : (65'(1) << (sh - 5'd1));
		for (int i = 0; i < 3; i++) begin
			rnd = ({1'b0, sc_s6[i]} + half) >> sh;
			if (rnd > (65'(1) << 30))
				rnd = 65'(1) << 30;
			n_c[i] = side_s6.neg[i] ? -signed'(32'(rnd)) : signed'(32'(rnd));
		end
	end

	// s7: unit vector in Q.30
	always_ff @(posedge clk) begin
		if (adv) begin
			n_s7    <= n_c;
			zero_s7 <= zero_s6;
		end
	end

	// s8: all component products of n and q
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 4; j++)
					pnq_s8[i][j] <= 64'(n_s7[i]) * 64'(qs[j]);
			zero_s8 <= zero_s7;
		end
	end

	// First Hamilton product (0,n)*conj(q), rounded to Q.27
	always_comb begin
		t_c[0] = 34'(qvr_pkg::shr_round(68'(pnq_s8[0][1]) + 68'(pnq_s8[1][2])
			+ 68'(pnq_s8[2][3]), 33));
		t_c[1] = 34'(qvr_pkg::shr_round(68'(pnq_s8[0][0]) - 68'(pnq_s8[1][3])
			+ 68'(pnq_s8[2][2]), 33));
		t_c[2] = 34'(qvr_pkg::shr_round(68'(pnq_s8[1][0]) - 68'(pnq_s8[2][1])
			+ 68'(pnq_s8[0][3]), 33));
		t_c[3] = 34'(qvr_pkg::shr_round(68'(pnq_s8[2][0]) - 68'(pnq_s8[0][2])
			+ 68'(pnq_s8[1][1]), 33));
	end

	// s9: intermediate quaternion t
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s9    <= t_c;
			zero_s9 <= zero_s8;
		end
	end

	// s10: all component products of q and t
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++)
				for (int m = 0; m < 4; m++)
					pqt_s10[j][m] <= 66'(qs[j]) * 66'(t_s9[m]);
			zero_s10 <= zero_s9;
		end
	end

	// Second Hamilton product q*t, rounded to Q.28 and saturated
	always_comb begin
		r_c[0] = qvr_pkg::sat32(qvr_pkg::shr_round(68'(pqt_s10[0][1]) + 68'(pqt_s10[1][0])
			+ 68'(pqt_s10[2][3]) - 68'(pqt_s10[3][2]), 29));
		r_c[1] = qvr_pkg::sat32(qvr_pkg::shr_round(68'(pqt_s10[0][2]) + 68'(pqt_s10[2][0])
			+ 68'(pqt_s10[3][1]) - 68'(pqt_s10[1][3]), 29));
		r_c[2] = qvr_pkg::sat32(qvr_pkg::shr_round(68'(pqt_s10[0][3]) + 68'(pqt_s10[3][0])
			+ 68'(pqt_s10[1][2]) - 68'(pqt_s10[2][1]), 29));
	end

	// Output register; force the zero vector result
	always_ff @(posedge clk) begin
		if (adv) begin
			rot.rot_x       <= zero_s10 ? '0 : r_c[0];
			rot.rot_y       <= zero_s10 ? '0 : r_c[1];
			rot.rot_z       <= zero_s10 ? '0 : r_c[2];
			rot.zero_vector <= zero_s10;
		end
	end

endmodule

// File: rtl/qvr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the quaternion vector rotator, with its bind.
module qvr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] rot_x,
	input logic [31:0] rot_y,
	input logic [31:0] rot_z,
	input logic        zero_vector
);

	// A zero vector result carries zero parts
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_vector |-> rot_x == '0 && rot_y == '0 && rot_z == '0)
		else $error("zero_vector set with nonzero rotation");

	// An empty output register never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output empty");

	// A result being taken frees the pipe for a new item
	a_ready_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// A held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rot_x) && $stable(rot_y)
			&& $stable(rot_z) && $stable(zero_vector))
		else $error("result changed while stalled");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (vec.valid),
	.in_ready    (vec.ready),
	.out_valid   (rot.valid),
	.out_ready   (rot.ready),
	.rot_x       (rot.rot_x),
	.rot_y       (rot.rot_y),
	.rot_z       (rot.rot_z),
	.zero_vector (rot.zero_vector)
);

// File: tb/quaternion_vector_rotate_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the quaternion vector rotator.
module quaternion_vector_rotate_tb;

	localparam int LATENCY     = 20;
	localparam int NEWTON_STEPS = 3;
	localparam int RANDOM_ITEMS = 550;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vector_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               zero;
	} rotation_t;

	// One directed row: input vector, and a typed-in result when it is obvious
	typedef struct {
		vector_t   v;
		bit        typed;
		rotation_t r;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [31:0] cfg_data;

	qvr_vec_if vec ();
	qvr_rot_if rot ();

	quaternion_vector_rotate dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.vec      (vec.sink),
		.rot      (rot.source),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Predictor copy of the quaternion registers
	logic signed [31:0] q_w, q_x, q_y, q_z;

	rotation_t expected_rotations[$];
	int        failures;
	longint    cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Seed of 1/sqrt(u) in Q2.12, indexed by the top four bits of u
	function automatic longint unsigned rsqrt_start(input int unsigned idx);
		case (idx)
			4: return 3862;
			5: return 3493;
			6: return 3213;
			7: return 2991;
			8: return 2810;
			9: return 2658;
			10: return 2528;
			11: return 2416;
			12: return 2317;
			13: return 2230;
			14: return 2151;
			15: return 2081;
			default: return 4096;
		endcase
	endfunction

	// Round right shift, half away from zero, on a wide signed value
	function automatic logic signed [127:0] round_shift(input logic signed [127:0] v,
			input int s);
		logic signed [127:0] half;
		logic signed [127:0] mag;
		half = 128'sd1 <<< (s - 1);
		if (v < 0) begin
			mag = -v;
			return -((mag + half) >>> s);
		end
		return (v + half) >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
		if (v > 128'sh7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (v < -128'sh8000_0000)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Normalize then rotate by q * (0,n) * conj(q)
	function automatic rotation_t rotate_vector(input vector_t v);
		rotation_t res;
		logic signed [63:0] comp[3];
		logic [63:0] mag;
		logic [63:0] sumsq;
		logic [63:0] u, y, t, p, three;
		logic signed [127:0] n[3];
		logic signed [127:0] w, x, yy, z, tw, tx, ty, tz;
		int k, sh;
		comp[0] = v.x;
		comp[1] = v.y;
		comp[2] = v.z;
		sumsq = 0;
		for (int i = 0; i < 3; i++) begin
			mag = comp[i] < 0 ? 64'(-comp[i]) : 64'(comp[i]);
			sumsq += mag * mag;
		end
		if (sumsq == 0) begin
			res = '0;
			res.zero = 1'b1;
			return res;
		end
		k = 0;
		while (((sumsq << k) >> 62) == 0)
			k += 2;
		u = (sumsq << k) >> 32;
		y = rsqrt_start(32'((u >> 28) & 15)) << 18;
		three = 64'd3 << 30;
		for (int it = 0; it < NEWTON_STEPS; it++) begin
			t = (y * y) >> 30;
			p = (t * u) >> 30;
			if (p >= three)
				y = 0;
			else
				y = (y * (three - p)) >> 31;
			y &= 64'hFFFF_FFFF;
		end
		sh = 31 - k / 2;
		for (int i = 0; i < 3; i++) begin
			mag = comp[i] < 0 ? 64'(-comp[i]) : 64'(comp[i]);
			mag *= y;
			if (sh > 0)
				mag = (mag + (64'd1 << (sh - 1))) >> sh;
			if (mag > (64'd1 << 30))
				mag = 64'd1 << 30;
			n[i] = comp[i] < 0 ? -$signed({64'd0, mag}) : $signed({64'd0, mag});
		end
		w = q_w;
		x = q_x;
		yy = q_y;
		z = q_z;
		tw = round_shift(n[0] * x + n[1] * yy + n[2] * z, 33);
		tx = round_shift(n[0] * w - n[1] * z + n[2] * yy, 33);
		ty = round_shift(n[1] * w - n[2] * x + n[0] * z, 33);
		tz = round_shift(n[2] * w - n[0] * yy + n[1] * x, 33);
		res.x = clamp32(round_shift(w * tx + x * tw + yy * tz - z * ty, 29));
		res.y = clamp32(round_shift(w * ty + yy * tw + z * tx - x * tz, 29));
		res.z = clamp32(round_shift(w * tz + z * tw + x * ty - yy * tx, 29));
		res.zero = 1'b0;
		return res;
	endfunction

	// Write one quaternion register; only called while the pipe is empty
	task automatic write_quat(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			qvr_pkg::REG_QUAT_W: q_w = data;
			qvr_pkg::REG_QUAT_X: q_x = data;
			qvr_pkg::REG_QUAT_Y: q_y = data;
			qvr_pkg::REG_QUAT_Z: q_z = data;
			default: ;
		endcase
	endtask

	task automatic load_quat(input logic [31:0] w, x, y, z);
		write_quat(qvr_pkg::REG_QUAT_W, w);
		write_quat(qvr_pkg::REG_QUAT_X, x);
		write_quat(qvr_pkg::REG_QUAT_Y, y);
		write_quat(qvr_pkg::REG_QUAT_Z, z);
	endtask

	// Drain: drop valid, wait until every expected item has come back, let the pipe settle
	task automatic drain_pipe();
		vec.valid <= 1'b0;
		while (expected_rotations.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Present one vector item, hold it until taken; gap drawn per item
	task automatic send_vector(input vector_t v, input bit typed, input rotation_t r);
		rotation_t pred;
		int gap;
		gap = $urandom_range(0, 14) * ($urandom_range(0, 3) != 0);
		if (gap != 0) begin
			vec.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		vec.valid <= 1'b1;
		vec.vec_x <= v.x;
		vec.vec_y <= v.y;
		vec.vec_z <= v.z;
		@(posedge clk);
		while (!vec.ready)
			@(posedge clk);
		pred = rotate_vector(v);
		if (typed && pred != r)
			$error("directed row disagrees with predictor for %h", v);
		expected_rotations.push_back(typed ? r : pred);
		@(negedge clk);
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'(int'($urandom_range(0, 200)) - 100);
			3: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic vector_t random_vector();
		vector_t v;
		v.x = random_word();
		v.y = random_word();
		v.z = random_word();
		if ($urandom_range(0, 40) == 0)
			v = '0;
		return v;
	endfunction

	// Quaternion settings: extremes in both directions, and random
	task automatic random_quat();
		case ($urandom_range(0, 3))
			0: load_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
			1: load_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
			2: load_quat($urandom >> 1, $urandom >> 2, $urandom >> 3, $urandom >> 2);
			default: load_quat($urandom, $urandom, $urandom, $urandom);
		endcase
	endtask

	// Result side: random stall per item, compare each accepted item with the oldest
	initial begin
		rotation_t want;
		int stall;
		rot.ready = 1'b0;
		failures = 0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				rot.ready <= 1'b0;
				stall--;
			end else begin
				rot.ready <= 1'b1;
			end
			@(posedge clk);
			if (rot.valid && rot.ready) begin
				if (expected_rotations.size() == 0) begin
					$error("unexpected result item x=%h y=%h z=%h", rot.rot_x, rot.rot_y,
						rot.rot_z);
					failures++;
				end else begin
					want = expected_rotations.pop_front();
					if (rot.rot_x !== want.x) begin
						$error("rot_x expected %h actual %h", want.x, rot.rot_x);
						failures++;
					end
					if (rot.rot_y !== want.y) begin
						$error("rot_y expected %h actual %h", want.y, rot.rot_y);
						failures++;
					end
					if (rot.rot_z !== want.z) begin
						$error("rot_z expected %h actual %h", want.z, rot.rot_z);
						failures++;
					end
					if (rot.zero_vector !== want.zero) begin
						$error("zero_vector expected %b actual %b", want.zero,
							rot.zero_vector);
						failures++;
					end
				end
				// No stall after one result in three, else a stall drawn uniformly
				stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
			end
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		directed_row_t rows[$];
		directed_row_t row;
		rotation_t none;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_idx    = qvr_pkg::REG_QUAT_W;
		cfg_data   = '0;
		vec.valid  = 1'b0;
		vec.vec_x  = '0;
		vec.vec_y  = '0;
		vec.vec_z  = '0;
		q_w = qvr_pkg::QUAT_W_RESET;
		q_x = '0;
		q_y = '0;
		q_z = '0;
		none = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Identity quaternion after reset: unit axes come back as 1.0 in Q3.28
		rows.push_back('{'{32'sd0, 32'sd0, 32'sd0}, 1'b1, '{0, 0, 0, 1'b1}});
		rows.push_back('{'{32'sh0001_0000, 0, 0}, 1'b1, '{32'sh1000_0000, 0, 0, 1'b0}});
		rows.push_back('{'{0, 32'sh0001_0000, 0}, 1'b1, '{0, 32'sh1000_0000, 0, 1'b0}});
		rows.push_back('{'{0, 0, 32'sh0001_0000}, 1'b1, '{0, 0, 32'sh1000_0000, 1'b0}});
		rows.push_back('{'{32'sh8000_0000, 0, 0}, 1'b1, '{32'shF000_0000, 0, 0, 1'b0}});
		rows.push_back('{'{0, 0, 32'sh7FFF_FFFF}, 0, none});
		rows.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 0, none});
		rows.push_back('{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 0, none});
		rows.push_back('{'{32'sd1, 0, 0}, 0, none});
		rows.push_back('{'{32'sd1, -32'sd1, 32'sd1}, 0, none});
		rows.push_back('{'{32'sh0003_0000, 32'sh0004_0000, 0}, 0, none});
		rows.push_back('{'{32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA}, 0, none});
		foreach (rows[i]) begin
			row = rows[i];
			send_vector(row.v, row.typed, row.r);
		end
		drain_pipe();

		// Large quaternion: saturation in both directions
		load_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		foreach (rows[i])
			send_vector(rows[i].v, 1'b0, none);
		drain_pipe();

		// Random items in phases, each with its own quaternion
		for (int phase = 0; phase < 11; phase++) begin
			random_quat();
			for (int i = 0; i < RANDOM_ITEMS / 11; i++) begin
				send_vector(random_vector(), 1'b0, none);
				// Hold off until the pipe has emptied, now and then
				if ($urandom_range(0, 60) == 0) begin
					vec.valid <= 1'b0;
					do
						@(negedge clk);
					while (expected_rotations.size() != 0);
				end
			end
			drain_pipe();
		end

		// Back to the identity at the end
		load_quat(qvr_pkg::QUAT_W_RESET, 0, 0, 0);
		for (int i = 0; i < 10; i++)
			send_vector(random_vector(), 1'b0, none);
		drain_pipe();

		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
